// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// ASSERT_STD is clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the standard clock and reset names
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== design/fdrd_pkg.sv =====
// Types, constants and constant-divide helpers for the ride display formatter.
// No dependencies; imported by every module of the block.
package fdrd_pkg;

  localparam logic [3:0]  BlankCode   = 4'd10;
  localparam logic [3:0]  MaxDigit    = 4'd9;
  localparam logic [13:0] MaxDistance = 14'd9999;
  localparam logic [6:0]  MaxMinutes  = 7'd99;

  typedef enum logic [1:0] {
    OpNone     = 2'd0,
    OpSpeed    = 2'd1,
    OpDistance = 2'd2,
    OpTime     = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [10:0] speed;
    logic [10:0] avg;
    logic        ez;
    logic [13:0] distance;
    logic [6:0]  mins;
    logic [5:0]  secs;
  } req_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       point;
  } pos_t;

  typedef struct packed {
    pos_t left;
    pos_t second;
    pos_t third;
    pos_t right;
  } disp_t;

  // x / 10 by reciprocal, exact for any 14-bit x
  function automatic logic [10:0] div10_14(input logic [13:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd52429;
    return p[29:19];
  endfunction

  // x / 100 by reciprocal, exact for any 14-bit x
  function automatic logic [7:0] div100_14(input logic [13:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd5243;
    return p[26:19];
  endfunction

  // x / 1000 by reciprocal, exact for any 14-bit x
  function automatic logic [4:0] div1000_14(input logic [13:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd8389;
    return p[27:23];
  endfunction

  // x / 10 by reciprocal, exact for any 7-bit x
  function automatic logic [3:0] div10_7(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

endpackage

// ===== design/fdrd_speed_pair.sv =====
// One speed pair: d.t below 10.0, two whole digits above, saturating at 99.
// Depends on fdrd_pkg for the divide helpers and pos_t.
module fdrd_speed_pair import fdrd_pkg::*; (
  input  logic [10:0] tenths_i,
  output pos_t        hi_o,
  output pos_t        lo_o
);

  logic [13:0] t14;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [3:0]  rem_tenth;
  logic [3:0]  rem_whole;

  assign t14       = 14'(tenths_i);
  assign q10       = div10_14(t14);
  assign q100      = div100_14(t14);
  assign rem_tenth = 4'(t14 - 14'(q10) * 14'd10);
  assign rem_whole = 4'(q10 - 11'(q100) * 11'd10);

  always_comb begin
    hi_o.point = 1'b0;
    lo_o.point = 1'b0;
    if (q10 < 11'd10) begin
      hi_o.digit = q10[3:0];
      hi_o.point = 1'b1;
      lo_o.digit = rem_tenth;
    end else if (q100 >= 8'd10) begin
      hi_o.digit = MaxDigit;
      lo_o.digit = MaxDigit;
    end else begin
      hi_o.digit = q100[3:0];
      lo_o.digit = rem_whole;
    end
  end

endmodule

// ===== design/fdrd_format.sv =====
// Digit formatter: speed, distance and time views of one request.
// Depends on fdrd_pkg and fdrd_speed_pair.
module fdrd_format import fdrd_pkg::*; (
  input  req_t  req_i,
  output disp_t disp_o
);

  logic [10:0] avg_sel;
  pos_t        cur_hi, cur_lo, avg_hi, avg_lo;

  logic [13:0] d_sat;
  logic [10:0] d_q10;
  logic [7:0]  d_q100;
  logic [4:0]  d_q1000;
  logic [3:0]  d_tenth, d_units, d_tens;

  logic [6:0]  m_sat;
  logic [3:0]  m_q10;
  logic [6:0]  s_ext;
  logic [3:0]  s_q10;

  assign avg_sel = req_i.ez ? 11'd0 : req_i.avg;

  fdrd_speed_pair u_cur_pair (
    .tenths_i (req_i.speed),
    .hi_o     (cur_hi),
    .lo_o     (cur_lo)
  );

  fdrd_speed_pair u_avg_pair (
    .tenths_i (avg_sel),
    .hi_o     (avg_hi),
    .lo_o     (avg_lo)
  );

  assign d_sat   = (req_i.distance > MaxDistance) ? MaxDistance : req_i.distance;
  assign d_q10   = div10_14(d_sat);
  assign d_q100  = div100_14(d_sat);
  assign d_q1000 = div1000_14(d_sat);
  assign d_tenth = 4'(d_sat - 14'(d_q10) * 14'd10);
  assign d_units = 4'(d_q10 - 11'(d_q100) * 11'd10);
  assign d_tens  = 4'(d_q100 - 8'(d_q1000) * 8'd10);

  assign m_sat = (req_i.mins > MaxMinutes) ? MaxMinutes : req_i.mins;
  assign m_q10 = div10_7(m_sat);
  assign s_ext = 7'(req_i.secs);
  assign s_q10 = div10_7(s_ext);

  always_comb begin
    disp_o = '0;
    unique case (req_i.op)
      OpSpeed: begin
        disp_o.left   = cur_hi;
        disp_o.second = cur_lo;
        disp_o.third  = avg_hi;
        disp_o.right  = avg_lo;
      end
      OpDistance: begin
        disp_o.left.digit   = (d_q1000 != 5'd0) ? 4'(d_q1000) : BlankCode;
        disp_o.second.digit = (d_q100 != 8'd0) ? d_tens : BlankCode;
        disp_o.third.digit  = d_units;
        disp_o.third.point  = 1'b1;
        disp_o.right.digit  = d_tenth;
      end
      OpTime: begin
        disp_o.left.digit   = m_q10;
        disp_o.second.digit = 4'(m_sat - 7'(m_q10) * 7'd10);
        disp_o.second.point = 1'b1;
        disp_o.third.digit  = s_q10;
        disp_o.right.digit  = 4'(s_ext - 7'(s_q10) * 7'd10);
      end
      OpNone: begin
        disp_o = '0;
      end
    endcase
  end

endmodule

// ===== design/four_digit_ride_display_formatter_top.sv =====
// Ride display formatter, top level: request register, formatter, result register.
// A request passes the request register and the formatter into the result register;
// one transaction per cycle is sustained while the output is not stalled, single formatter pass.
// A no-update request is taken and produces no result.
// Reset (rst_ni low, asynchronous) clears both valid flags; payload is not reset.
module four_digit_ride_display_formatter_top import fdrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [10:0] speed_tenths_i,
  input  logic [10:0] average_tenths_i,
  input  logic        elapsed_is_zero_i,
  input  logic [13:0] distance_tenths_i,
  input  logic [6:0]  minutes_count_i,
  input  logic [5:0]  seconds_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  left_digit_o,
  output logic        left_point_o,
  output logic [3:0]  second_digit_o,
  output logic        second_point_o,
  output logic [3:0]  third_digit_o,
  output logic        third_point_o,
  output logic [3:0]  right_digit_o,
  output logic        right_point_o
);

  req_t  req_d, req_q;
  logic  req_valid_d, req_valid_q;
  disp_t disp_d, disp_q;
  logic  out_valid_d, out_valid_q;
  logic  out_adv;
  logic  in_take;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign req_d.op       = op_e'(operation_i);
  assign req_d.speed    = speed_tenths_i;
  assign req_d.avg      = average_tenths_i;
  assign req_d.ez       = elapsed_is_zero_i;
  assign req_d.distance = distance_tenths_i;
  assign req_d.mins     = minutes_count_i;
  assign req_d.secs     = seconds_count_i;

  always_comb begin
    req_valid_d = req_valid_q;
    if (!in_stall_o) begin
      req_valid_d = in_take && (req_d.op != OpNone);
    end
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = req_valid_q;
    end
  end

  fdrd_format u_format (
    .req_i  (req_q),
    .disp_o (disp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      req_q <= req_d;
    end
    if (out_adv && req_valid_q) begin
      disp_q <= disp_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_digit_o   = disp_q.left.digit;
  assign left_point_o   = disp_q.left.point;
  assign second_digit_o = disp_q.second.digit;
  assign second_point_o = disp_q.second.point;
  assign third_digit_o  = disp_q.third.digit;
  assign third_point_o  = disp_q.third.point;
  assign right_digit_o  = disp_q.right.digit;
  assign right_point_o  = disp_q.right.point;

endmodule

// ===== design/fdrd_checker.sv =====
// Port-level checks for the ride display formatter, bound to the top level.
// Depends on fdrd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fdrd_checker import fdrd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  operation_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  left_digit_o,
  input logic        left_point_o,
  input logic [3:0]  second_digit_o,
  input logic        second_point_o,
  input logic [3:0]  right_digit_o,
  input logic        third_point_o,
  input logic        right_point_o
);

  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(left_digit_o), "stalled result dropped or changed")
  `ASSERT_STD(a_latency, in_valid_i && !in_stall_o && operation_i != OpNone ##1 !out_stall_i |=> out_valid_o, "result missing two cycles after transaction")
  `ASSERT_STD(a_no_right_point, out_valid_o |-> !right_point_o, "rightmost point lit")
  `ASSERT_STD(a_time_padded, out_valid_o && second_point_o |-> left_digit_o <= MaxDigit && right_digit_o <= MaxDigit, "time view shows a blank")
  `ASSERT_STD(a_blank_distance, out_valid_o && left_digit_o == BlankCode |-> !left_point_o && third_point_o && second_digit_o != BlankCode || second_digit_o == BlankCode, "blank outside distance view")

endmodule

bind four_digit_ride_display_formatter_top fdrd_checker u_fdrd_checker (.*);

// ===== tb/tb_four_digit_ride_display_formatter_top.sv =====
// Testbench for four_digit_ride_display_formatter_top: directed and random display requests,
// checked against an in-bench digit predictor through a small scoreboard class.
// Depends on fdrd_pkg for the request, result and operation types.
module tb_four_digit_ride_display_formatter_top import fdrd_pkg::*; ();

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 300;
  localparam int PhaseItems    = 160;

  class display_scoreboard;
    disp_t expected_q[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    function void speed_pair(input int tenths, output pos_t hi, output pos_t lo);
      int whole;
      hi = '0;
      lo = '0;
      if (tenths >= 100) begin
        whole = tenths / 10;
        if (whole > 99) whole = 99;
        hi.digit = 4'(whole / 10);
        lo.digit = 4'(whole % 10);
      end else begin
        hi.digit = 4'(tenths / 10);
        hi.point = 1'b1;
        lo.digit = 4'(tenths % 10);
      end
    endfunction

    function disp_t format_display(req_t r);
      disp_t d;
      int    dist_val;
      int    whole;
      int    mins;
      d = '0;
      case (r.op)
        OpSpeed: begin
          speed_pair(int'(r.speed), d.left, d.second);
          speed_pair(r.ez ? 0 : int'(r.avg), d.third, d.right);
        end
        OpDistance: begin
          dist_val = (r.distance > MaxDistance) ? int'(MaxDistance) : int'(r.distance);
          whole = dist_val / 10;
          d.left.digit   = (whole >= 100) ? 4'(whole / 100) : BlankCode;
          d.second.digit = (whole >= 10) ? 4'((whole / 10) % 10) : BlankCode;
          d.third.digit  = 4'(whole % 10);
          d.third.point  = 1'b1;
          d.right.digit  = 4'(dist_val % 10);
        end
        OpTime: begin
          mins = (r.mins > MaxMinutes) ? int'(MaxMinutes) : int'(r.mins);
          d.left.digit   = 4'(mins / 10);
          d.second.digit = 4'(mins % 10);
          d.second.point = 1'b1;
          d.third.digit  = 4'(r.secs / 10);
          d.right.digit  = 4'(r.secs % 10);
        end
        default: ;
      endcase
      return d;
    endfunction

    function void note_request(req_t r);
      if (r.op != OpNone) expected_q.insert(expected_q.size(), format_display(r));
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(disp_t got);
      disp_t exp_d;
      if (expected_q.size() == 0) begin
        $error("unexpected display transaction %h", got);
        errors++;
        return;
      end
      exp_d = expected_q.pop_front();
      compare_field("left_digit", exp_d.left.digit, got.left.digit);
      compare_field("left_point", exp_d.left.point, got.left.point);
      compare_field("second_digit", exp_d.second.digit, got.second.digit);
      compare_field("second_point", exp_d.second.point, got.second.point);
      compare_field("third_digit", exp_d.third.digit, got.third.digit);
      compare_field("third_point", exp_d.third.point, got.third.point);
      compare_field("right_digit", exp_d.right.digit, got.right.digit);
      compare_field("right_point", exp_d.right.point, got.right.point);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [10:0] speed_tenths_i = '0;
  logic [10:0] average_tenths_i = '0;
  logic        elapsed_is_zero_i = 1'b0;
  logic [13:0] distance_tenths_i = '0;
  logic [6:0]  minutes_count_i = '0;
  logic [5:0]  seconds_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  left_digit_o;
  logic        left_point_o;
  logic [3:0]  second_digit_o;
  logic        second_point_o;
  logic [3:0]  third_digit_o;
  logic        third_point_o;
  logic [3:0]  right_digit_o;
  logic        right_point_o;

  disp_t display_bus;
  display_scoreboard sb;
  req_t directed_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  assign display_bus = {left_digit_o, left_point_o, second_digit_o, second_point_o,
                        third_digit_o, third_point_o, right_digit_o, right_point_o};

  four_digit_ride_display_formatter_top u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .speed_tenths_i,
    .average_tenths_i,
    .elapsed_is_zero_i,
    .distance_tenths_i,
    .minutes_count_i,
    .seconds_count_i,
    .out_valid_o,
    .out_stall_i,
    .left_digit_o,
    .left_point_o,
    .second_digit_o,
    .second_point_o,
    .third_digit_o,
    .third_point_o,
    .right_digit_o,
    .right_point_o
  );

  always #1 clk_i = ~clk_i;

  // Check results and drive the output stall, with long hold-offs on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(display_bus);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      holds_done <= holds_done + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void add_directed(input req_t r);
    directed_q.insert(directed_q.size(), r);
  endfunction

  function automatic req_t make_request(op_e op, int spd, int avg, bit ez, int dist_val,
                                        int mins, int secs);
    req_t r;
    r.op       = op;
    r.speed    = 11'(spd);
    r.avg      = 11'(avg);
    r.ez       = ez;
    r.distance = 14'(dist_val);
    r.mins     = 7'(mins);
    r.secs     = 6'(secs);
    return r;
  endfunction

  function automatic logic [10:0] rand_speed();
    case ($urandom_range(2))
      0: return 11'($urandom_range(99));
      1: return 11'($urandom_range(999, 100));
      default: return 11'($urandom_range(2047));
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t r;
    r.op    = ($urandom_range(9) == 0) ? OpNone : op_e'($urandom_range(3, 1));
    r.speed = rand_speed();
    r.avg   = rand_speed();
    r.ez    = ($urandom_range(3) == 0);
    case ($urandom_range(4))
      0: r.distance = 14'($urandom_range(9));
      1: r.distance = 14'($urandom_range(99));
      2: r.distance = 14'($urandom_range(999));
      3: r.distance = 14'($urandom_range(9999));
      default: r.distance = 14'($urandom_range(16383));
    endcase
    r.mins  = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(99));
    r.secs  = 6'($urandom_range(63));
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= r.op;
    speed_tenths_i    <= r.speed;
    average_tenths_i  <= r.avg;
    elapsed_is_zero_i <= r.ez;
    distance_tenths_i <= r.distance;
    minutes_count_i   <= r.mins;
    seconds_count_i   <= r.secs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // Drop valid and wait for every expected transaction, plus pipeline latency
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    req_t r;
    int   idle_pcts[4];
    int   stall_pcts[4];
    int   sent;

    sb = new();
    idle_pcts  = '{0, 56, 0, 13};
    stall_pcts = '{0, 0, 56, 13};

    add_directed(make_request(OpNone, 2047, 2047, 1'b1, 16383, 127, 63));
    add_directed(make_request(OpSpeed, 0, 0, 1'b0, 0, 0, 0));
    add_directed(make_request(OpSpeed, 99, 100, 1'b0, 0, 0, 0));
    add_directed(make_request(OpSpeed, 100, 999, 1'b0, 0, 0, 0));
    add_directed(make_request(OpSpeed, 999, 1000, 1'b0, 0, 0, 0));
    add_directed(make_request(OpSpeed, 2047, 2047, 1'b0, 0, 0, 0));
    add_directed(make_request(OpSpeed, 55, 2047, 1'b1, 0, 0, 0));
    add_directed(make_request(OpSpeed, 1000, 5, 1'b0, 0, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 0, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 9, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 10, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 99, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 100, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 999, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 1000, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 9999, 0, 0));
    add_directed(make_request(OpDistance, 0, 0, 1'b0, 10000, 0, 0));
    add_directed(make_request(OpDistance, 2047, 2047, 1'b1, 16383, 127, 63));
    add_directed(make_request(OpTime, 0, 0, 1'b0, 0, 0, 0));
    add_directed(make_request(OpTime, 0, 0, 1'b0, 0, 99, 59));
    add_directed(make_request(OpTime, 0, 0, 1'b0, 0, 100, 60));
    add_directed(make_request(OpTime, 2047, 2047, 1'b1, 16383, 127, 63));
    add_directed(make_request(OpTime, 0, 0, 1'b0, 0, 5, 7));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_request(directed_q[i]);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_pcts[p];
      stall_pct = stall_pcts[p];
      sent = 0;
      while (sent < PhaseItems) begin
        r = rand_request();
        send_request(r);
        if (r.op != OpNone) sent++;
      end
      drain();
    end

    // Hold the output side off while the input keeps offering transactions
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests = hold_requests + 1;
    repeat (40) send_request(rand_request());
    drain();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/fdrd_pkg.sv
design/fdrd_speed_pair.sv
design/fdrd_format.sv
design/four_digit_ride_display_formatter_top.sv
design/fdrd_checker.sv
tb/tb_four_digit_ride_display_formatter_top.sv
